// ----- sv/mhtq_pkg.sv -----
// Shared types, constants and helper functions for the min-heap timer queue.
// No dependencies; every other file of the block imports this package.
package mhtq_pkg;

    localparam int SLOTS    = 32;
    localparam int SLOT_W   = $clog2(SLOTS);
    localparam int CNT_W    = $clog2(SLOTS + 1);
    localparam int ID_COUNT = 1024;
    localparam int ID_W     = $clog2(ID_COUNT);
    localparam int TIME_W   = 32;
    localparam int TMO_W    = 31;
    localparam int CMD_W    = 3;
    localparam int WAIT_W   = 32;

    typedef enum logic [CMD_W-1:0] {
        CMD_ADD       = 3'd0,
        CMD_ADJUST    = 3'd1,
        CMD_EXPIRE    = 3'd2,
        CMD_POP       = 3'd3,
        CMD_CLEAR     = 3'd4,
        CMD_NEXT_WAIT = 3'd5
    } cmd_t;

    localparam logic [1:0] KIND_ACK     = 2'd0;
    localparam logic [1:0] KIND_EXPIRED = 2'd1;
    localparam logic [1:0] KIND_WAIT    = 2'd2;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_FULL    = 2'd1;
    localparam logic [1:0] ST_UNKNOWN = 2'd2;
    localparam logic [1:0] ST_EMPTY   = 2'd3;

    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic [TIME_W-1:0] expiry;
    } heap_ent_t;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_CLR_STEP,
        OP_LOAD,
        OP_MAP_RD,
        OP_HEAP_RD_MAP,
        OP_START_REARM,
        OP_START_ADD,
        OP_RD_C,
        OP_LATCH_A,
        OP_DN_STEP,
        OP_RD_P,
        OP_UP_STEP,
        OP_PUT,
        OP_REM_START,
        OP_REM_LOAD,
        OP_RD_TOP,
        OP_TAKE,
        OP_EMIT_ACK,
        OP_CLEAR,
        OP_FLUSH_PEND,
        OP_FIN_EXP,
        OP_FIN_WAIT
    } op_t;

    typedef struct packed {
        op_t        op;
        logic [1:0] status;
    } ctl_t;

    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic count_zero;
        logic count_full;
        logic held;
        logic has_c;
        logic dn_stop;
        logic moved;
        logic idx_zero;
        logic up_stop;
        logic rem_has;
        logic due;
        logic pend_valid;
        logic out_free;
        logic clr_last;
    } sts_t;

    typedef enum logic [4:0] {
        S_CLR,
        S_IDLE,
        S_DECODE,
        S_MAPW,
        S_HCHK,
        S_REM,
        S_REML,
        S_DN,
        S_DNA,
        S_DNB,
        S_DNEND,
        S_UP,
        S_UPA,
        S_PUT,
        S_TOP,
        S_TOPW,
        S_FIN,
        S_ACK
    } state_t;

    // Wrap-safe order: a is earlier than b when a - b is negative.
    function automatic logic earlier(input logic [TIME_W-1:0] a, input logic [TIME_W-1:0] b);
        logic [TIME_W-1:0] d;
        d = a - b;
        return d[TIME_W-1];
    endfunction

endpackage

// ----- sv/mhtq_ctrl.sv -----
// Sequencer of the min-heap timer queue: walks each command through its steps.
// Depends on mhtq_pkg; drives mhtq_dp through a command struct.
module mhtq_ctrl (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_tvalid,
    output logic           s_tready,
    input  mhtq_pkg::sts_t sts,
    output mhtq_pkg::ctl_t ctl
);
    import mhtq_pkg::*;

    state_t     state_reg, state_next;
    logic [1:0] ack_st_reg, ack_st_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_CLR;
            ack_st_reg <= ST_OK;
        end else begin
            state_reg  <= state_next;
            ack_st_reg <= ack_st_next;
        end
    end

    always_comb begin
        state_next  = state_reg;
        ack_st_next = ack_st_reg;
        ctl.op      = OP_NONE;
        ctl.status  = ack_st_reg;
        s_tready    = 1'b0;
        case (state_reg)
            S_CLR: begin
                ctl.op = OP_CLR_STEP;
                if (sts.clr_last) state_next = S_IDLE;
            end
            S_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    ctl.op     = OP_LOAD;
                    state_next = S_DECODE;
                end
            end
            S_DECODE: begin
                ack_st_next = ST_OK;
                case (sts.cmd)
                    CMD_ADD, CMD_ADJUST: begin
                        ctl.op     = OP_MAP_RD;
                        state_next = S_MAPW;
                    end
                    CMD_EXPIRE, CMD_NEXT_WAIT: state_next = S_TOP;
                    CMD_POP: begin
                        if (sts.count_zero) begin
                            ack_st_next = ST_EMPTY;
                            state_next  = S_ACK;
                        end else begin
                            state_next = S_REM;
                        end
                    end
                    CMD_CLEAR: begin
                        ctl.op     = OP_CLEAR;
                        state_next = S_ACK;
                    end
                    default: state_next = S_ACK;
                endcase
            end
            S_MAPW: begin
                ctl.op     = OP_HEAP_RD_MAP;
                state_next = S_HCHK;
            end
            S_HCHK: begin
                if (sts.held) begin
                    ctl.op     = OP_START_REARM;
                    state_next = S_DN;
                end else if (sts.cmd == CMD_ADJUST) begin
                    ack_st_next = ST_UNKNOWN;
                    state_next  = S_ACK;
                end else if (sts.count_full) begin
                    ack_st_next = ST_FULL;
                    state_next  = S_ACK;
                end else begin
                    ctl.op     = OP_START_ADD;
                    state_next = S_DN;
                end
            end
            S_REM: begin
                ctl.op = OP_REM_START;
                if (sts.rem_has) state_next = S_REML;
                else if (sts.cmd == CMD_POP) state_next = S_ACK;
                else state_next = S_TOP;
            end
            S_REML: begin
                ctl.op     = OP_REM_LOAD;
                state_next = S_DN;
            end
            S_DN: begin
                if (sts.has_c) begin
                    ctl.op     = OP_RD_C;
                    state_next = S_DNA;
                end else begin
                    state_next = S_DNEND;
                end
            end
            S_DNA: begin
                ctl.op     = OP_LATCH_A;
                state_next = S_DNB;
            end
            S_DNB: begin
                ctl.op     = OP_DN_STEP;
                state_next = sts.dn_stop ? S_DNEND : S_DN;
            end
            S_DNEND: state_next = sts.moved ? S_PUT : S_UP;
            S_UP: begin
                if (sts.idx_zero) begin
                    state_next = S_PUT;
                end else begin
                    ctl.op     = OP_RD_P;
                    state_next = S_UPA;
                end
            end
            S_UPA: begin
                ctl.op     = OP_UP_STEP;
                state_next = sts.up_stop ? S_PUT : S_UP;
            end
            S_PUT: begin
                ctl.op = OP_PUT;
                if (sts.cmd == CMD_EXPIRE || sts.cmd == CMD_NEXT_WAIT) state_next = S_TOP;
                else state_next = S_ACK;
            end
            S_TOP: begin
                if (sts.count_zero) begin
                    state_next = S_FIN;
                end else begin
                    ctl.op     = OP_RD_TOP;
                    state_next = S_TOPW;
                end
            end
            S_TOPW: begin
                if (!sts.due) begin
                    state_next = S_FIN;
                end else if (!sts.pend_valid || sts.out_free) begin
                    ctl.op     = OP_TAKE;
                    state_next = S_REM;
                end
            end
            S_FIN: begin
                if (sts.out_free) begin
                    if (sts.cmd == CMD_NEXT_WAIT) begin
                        if (sts.pend_valid) begin
                            ctl.op = OP_FLUSH_PEND;
                        end else begin
                            ctl.op     = OP_FIN_WAIT;
                            state_next = S_IDLE;
                        end
                    end else begin
                        ctl.op     = OP_FIN_EXP;
                        state_next = S_IDLE;
                    end
                end
            end
            S_ACK: begin
                if (sts.out_free) begin
                    ctl.op     = OP_EMIT_ACK;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

endmodule

// ----- sv/mhtq_dp.sv -----
// Datapath of the min-heap timer queue: heap memory, id-to-slot map memory,
// sift registers and the result register. Depends on mhtq_pkg.
module mhtq_dp (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic [79:0]                     s_tdata,
    input  mhtq_pkg::ctl_t                  ctl,
    output mhtq_pkg::sts_t                  sts,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [47:0]                     m_tdata,
    output logic [1:0]                      m_tuser,
    output logic                            m_tlast
);
    import mhtq_pkg::*;

    heap_ent_t         heap_mem [SLOTS];
    logic [SLOT_W-1:0] map_mem  [ID_COUNT];

    heap_ent_t         heap_rd_reg;
    logic [SLOT_W-1:0] map_rd_reg;

    logic [CMD_W-1:0]  cmd_reg;
    logic [ID_W-1:0]   id_reg;
    logic [TIME_W-1:0] exp_reg;
    logic [TIME_W-1:0] now_reg;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  lim_reg;
    logic [SLOT_W-1:0] idx_reg;
    logic [SLOT_W-1:0] start_reg;
    heap_ent_t         e_reg;
    heap_ent_t         a_reg;
    logic              pend_valid_reg;
    logic [ID_W-1:0]   pend_id_reg;
    logic [ID_W-1:0]   clr_reg;

    logic              out_valid_reg;
    logic [1:0]        out_kind_reg;
    logic [ID_W-1:0]   out_id_reg;
    logic [WAIT_W-1:0] out_wait_reg;
    logic [1:0]        out_st_reg;
    logic              out_last_reg;

    logic [CNT_W-1:0]  c_idx;
    logic [CNT_W:0]    c1_idx;
    logic              has_c1;
    logic              pick_b;
    heap_ent_t         chosen;
    logic [SLOT_W-1:0] chosen_idx;
    logic              dn_stop;
    logic [SLOT_W-1:0] idx_m1;
    logic [SLOT_W-1:0] p_idx;
    logic              up_stop;
    logic [TIME_W-1:0] d_top;
    logic              due;
    logic              out_free;
    logic              out_set;
    logic [CNT_W-1:0]  count_m1;

    logic              heap_re;
    logic [SLOT_W-1:0] heap_raddr;
    logic              heap_we;
    heap_ent_t         heap_wdata;
    logic              map_we;
    logic [ID_W-1:0]   map_waddr;
    logic [SLOT_W-1:0] map_wdata;

    assign c_idx      = {idx_reg, 1'b1};
    assign c1_idx     = {1'b0, c_idx} + 1'b1;
    assign has_c1     = c1_idx < {1'b0, lim_reg};
    assign pick_b     = has_c1 && earlier(heap_rd_reg.expiry, a_reg.expiry);
    assign chosen     = pick_b ? heap_rd_reg : a_reg;
    assign chosen_idx = pick_b ? c1_idx[SLOT_W-1:0] : c_idx[SLOT_W-1:0];
    assign dn_stop    = earlier(e_reg.expiry, chosen.expiry);
    assign idx_m1     = idx_reg - 1'b1;
    assign p_idx      = {1'b0, idx_m1[SLOT_W-1:1]};
    assign up_stop    = earlier(heap_rd_reg.expiry, e_reg.expiry);
    assign d_top      = heap_rd_reg.expiry - now_reg;
    assign due        = (d_top == '0) || d_top[TIME_W-1];
    assign out_free   = !out_valid_reg || m_tready;
    assign count_m1   = count_reg - 1'b1;

    // A new result is loaded into the output register on these steps.
    assign out_set = ((ctl.op == OP_TAKE) && pend_valid_reg) ||
                     (ctl.op == OP_EMIT_ACK) || (ctl.op == OP_FIN_WAIT) ||
                     (ctl.op == OP_FLUSH_PEND) || (ctl.op == OP_FIN_EXP);

    assign sts.cmd        = cmd_reg;
    assign sts.count_zero = (count_reg == '0);
    assign sts.count_full = (count_reg == CNT_W'(SLOTS));
    assign sts.held       = ({1'b0, map_rd_reg} < count_reg) && (heap_rd_reg.id == id_reg);
    assign sts.has_c      = c_idx < lim_reg;
    assign sts.dn_stop    = dn_stop;
    assign sts.moved      = (idx_reg != start_reg);
    assign sts.idx_zero   = (idx_reg == '0);
    assign sts.up_stop    = up_stop;
    assign sts.rem_has    = (count_reg > CNT_W'(1));
    assign sts.due        = due;
    assign sts.pend_valid = pend_valid_reg;
    assign sts.out_free   = out_free;
    assign sts.clr_last   = (clr_reg == ID_W'(ID_COUNT - 1));

    // Memory port selection for the current step.
    always_comb begin
        heap_re    = 1'b0;
        heap_raddr = '0;
        heap_we    = 1'b0;
        heap_wdata = e_reg;
        map_we     = 1'b0;
        map_waddr  = e_reg.id;
        map_wdata  = idx_reg;
        case (ctl.op)
            OP_HEAP_RD_MAP: begin
                heap_re    = 1'b1;
                heap_raddr = map_rd_reg;
            end
            OP_RD_C: begin
                heap_re    = 1'b1;
                heap_raddr = c_idx[SLOT_W-1:0];
            end
            OP_LATCH_A: begin
                heap_re    = has_c1;
                heap_raddr = c1_idx[SLOT_W-1:0];
            end
            OP_RD_P: begin
                heap_re    = 1'b1;
                heap_raddr = p_idx;
            end
            OP_REM_START: begin
                heap_re    = (count_reg > CNT_W'(1));
                heap_raddr = count_m1[SLOT_W-1:0];
            end
            OP_RD_TOP: begin
                heap_re    = 1'b1;
                heap_raddr = '0;
            end
            OP_DN_STEP: begin
                heap_we    = !dn_stop;
                heap_wdata = chosen;
                map_we     = !dn_stop;
                map_waddr  = chosen.id;
            end
            OP_UP_STEP: begin
                heap_we    = !up_stop;
                heap_wdata = heap_rd_reg;
                map_we     = !up_stop;
                map_waddr  = heap_rd_reg.id;
            end
            OP_PUT: begin
                heap_we = 1'b1;
                map_we  = 1'b1;
            end
            OP_CLR_STEP: begin
                map_we    = 1'b1;
                map_waddr = clr_reg;
                map_wdata = '0;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (heap_we) heap_mem[idx_reg] <= heap_wdata;
        if (heap_re) heap_rd_reg <= heap_mem[heap_raddr];
    end

    always_ff @(posedge aclk) begin
        if (map_we) map_mem[map_waddr] <= map_wdata;
        if (ctl.op == OP_MAP_RD) map_rd_reg <= map_mem[id_reg];
    end

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg      <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            clr_reg        <= '0;
        end else begin
            if (out_set) out_valid_reg <= 1'b1;
            else if (m_tready) out_valid_reg <= 1'b0;
            case (ctl.op)
                OP_CLR_STEP:   clr_reg <= clr_reg + 1'b1;
                OP_LOAD:       pend_valid_reg <= 1'b0;
                OP_START_ADD:  count_reg <= count_reg + 1'b1;
                OP_REM_START:  count_reg <= count_m1;
                OP_CLEAR:      count_reg <= '0;
                OP_TAKE:       pend_valid_reg <= 1'b1;
                OP_FLUSH_PEND, OP_FIN_EXP: pend_valid_reg <= 1'b0;
                default: ;
            endcase
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        case (ctl.op)
            OP_LOAD: begin
                cmd_reg <= s_tdata[2:0];
                id_reg  <= s_tdata[12:3];
                now_reg <= s_tdata[75:44];
                exp_reg <= s_tdata[75:44] + {1'b0, s_tdata[43:13]};
            end
            OP_START_REARM: begin
                e_reg     <= '{id: id_reg, expiry: exp_reg};
                idx_reg   <= map_rd_reg;
                start_reg <= map_rd_reg;
                lim_reg   <= count_reg;
            end
            OP_START_ADD: begin
                e_reg     <= '{id: id_reg, expiry: exp_reg};
                idx_reg   <= count_reg[SLOT_W-1:0];
                start_reg <= count_reg[SLOT_W-1:0];
                lim_reg   <= count_reg + 1'b1;
            end
            OP_LATCH_A:   a_reg <= heap_rd_reg;
            OP_DN_STEP:   if (!dn_stop) idx_reg <= chosen_idx;
            OP_UP_STEP:   if (!up_stop) idx_reg <= p_idx;
            OP_REM_START: lim_reg <= count_m1;
            OP_REM_LOAD: begin
                e_reg     <= heap_rd_reg;
                idx_reg   <= '0;
                start_reg <= '0;
            end
            OP_TAKE: begin
                pend_id_reg <= heap_rd_reg.id;
                // The output register is only touched when the held id goes out.
                if (pend_valid_reg) begin
                    out_kind_reg <= KIND_EXPIRED;
                    out_id_reg   <= pend_id_reg;
                    out_wait_reg <= '0;
                    out_st_reg   <= ST_OK;
                    out_last_reg <= 1'b0;
                end
            end
            OP_EMIT_ACK: begin
                out_kind_reg <= KIND_ACK;
                out_id_reg   <= '0;
                out_wait_reg <= '0;
                out_st_reg   <= ctl.status;
                out_last_reg <= 1'b1;
            end
            OP_FLUSH_PEND, OP_FIN_EXP: begin
                out_kind_reg <= pend_valid_reg ? KIND_EXPIRED : KIND_ACK;
                out_id_reg   <= pend_valid_reg ? pend_id_reg : '0;
                out_wait_reg <= '0;
                out_st_reg   <= ST_OK;
                out_last_reg <= (ctl.op == OP_FIN_EXP);
            end
            OP_FIN_WAIT: begin
                out_kind_reg <= KIND_WAIT;
                out_id_reg   <= '0;
                if (count_reg == '0) out_wait_reg <= '1;
                else if (d_top[TIME_W-1]) out_wait_reg <= '0;
                else out_wait_reg <= d_top;
                out_st_reg   <= ST_OK;
                out_last_reg <= 1'b1;
            end
            default: ;
        endcase
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'b0, out_st_reg, out_wait_reg, out_id_reg};
    assign m_tuser  = out_kind_reg;
    assign m_tlast  = out_last_reg;

endmodule

// ----- sv/min_heap_timer_queue.sv -----
// Top level of the min-heap timer queue: sequencer plus datapath.
// Depends on mhtq_pkg, mhtq_ctrl and mhtq_dp.
//
//  Channel | Direction | Content
//  --------+-----------+------------------------------------------------------
//  s_      | in        | tdata: cmd, timer_id, timeout_ms, now_ms (80 bits)
//  m_      | out       | tdata: expired_id, wait_ms, status; tuser: kind; tlast
//
// A command without expiries passes at least through accept, decode and result;
// each heap level takes the states S_DN, S_DNA and S_DNB going down and S_UP and
// S_UPA going up, set by the single read port of the heap memory, and each expired
// timer adds the read of the top, its removal and its sift down.
// After reset a clearing pass writes all 1024 id map entries, one per cycle,
// and no input transfer is taken until it ends.
// A stalled result register holds the sequencer only when it must emit again.
module min_heap_timer_queue (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [79:0] s_tdata,   // cmd[2:0], timer_id[12:3], timeout_ms[43:13], now_ms[75:44]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // expired_id[9:0], wait_ms[41:10], status[43:42]
    output logic [1:0]  m_tuser,   // kind[1:0]
    output logic        m_tlast
);
    import mhtq_pkg::*;

    ctl_t ctl;
    sts_t sts;

    // The sequencer takes one command at a time and steps the datapath.
    mhtq_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .ctl      (ctl)
    );

    // The datapath holds the heap, the id map and the result register.
    mhtq_dp u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .ctl      (ctl),
        .sts      (sts),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule
